### src/plsort_pkg.sv
// shared types, constants and helpers of the pair sorter
`default_nettype none
package plsort_pkg;

   localparam int KEY_W         = 32;
   localparam int PAIR_W        = 2 * KEY_W;
   localparam int MAX_PAIRS_DEF = 64;

   localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

   typedef struct packed {
      logic load_item;
      logic rd_en;
      logic rd_emit;
      logic wr_en;
      logic wr_shift;
      logic j_dec;
      logic count_inc;
      logic count_clear;
      logic k_inc;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic j_zero;
      logic greater;
      logic last;
      logic k_last;
   } status_type;

   // sign bits inverted so an unsigned compare gives the lexicographic order
   function automatic logic [PAIR_W-1:0] pack_pair(input logic [KEY_W-1:0] first,
                                                   input logic [KEY_W-1:0] second);
      pack_pair = {first ^ SIGN_FLIP, second ^ SIGN_FLIP};
   endfunction

endpackage
`default_nettype wire

### src/pair_lexicographic_sorter.sv
// top level of the lexicographic pair sorter
// Pairs of signed 32-bit keys arrive one transaction at a time and are
// insertion-sorted into a store of MAX_PAIRS entries with one write port and
// one read port as they come, ordered by the first key with ties broken by the
// second. A pair that arrives with the store full is dropped, but its
// batch_last flag still closes the batch. Each stored input transaction runs
// the compare-and-shift loop down from the top of the store, one store read
// and one write per step, with the registered read of the store, until it
// meets an entry not greater than it or reaches the bottom. When batch_last is
// seen the sorted run is emitted, each pair read, loaded into the output
// register and held through any stall, with run_last on the final pair; no
// input is accepted until the run has been taken.
`default_nettype none
module pair_lexicographic_sorter
   import plsort_pkg::*;
#(
   parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [KEY_W-1:0] req_key_first,
   input  wire logic signed [KEY_W-1:0] req_key_second,
   input  wire logic                    req_batch_last,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [KEY_W-1:0]      rsp_sorted_first,
   output logic signed [KEY_W-1:0]      rsp_sorted_second,
   output logic                         rsp_run_last
);

   cmd_type    cmd;
   status_type status;

   plsort_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_batch_last (req_batch_last),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   plsort_dpath #(
      .MAX_PAIRS (MAX_PAIRS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_key_first     (req_key_first),
      .req_key_second    (req_key_second),
      .req_batch_last    (req_batch_last),
      .cmd               (cmd),
      .status            (status),
      .rsp_sorted_first  (rsp_sorted_first),
      .rsp_sorted_second (rsp_sorted_second),
      .rsp_run_last      (rsp_run_last)
   );

endmodule
`default_nettype wire

### src/plsort_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module plsort_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/plsort_dpath.sv
// datapath: pair store, insertion pointer, counters and output registers
`default_nettype none
module plsort_dpath
   import plsort_pkg::*;
#(
   parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic signed [KEY_W-1:0] req_key_first,
   input  wire logic signed [KEY_W-1:0] req_key_second,
   input  wire logic                    req_batch_last,
   input  wire cmd_type                 cmd,
   output status_type                   status,
   output logic signed [KEY_W-1:0]      rsp_sorted_first,
   output logic signed [KEY_W-1:0]      rsp_sorted_second,
   output logic                         rsp_run_last
);

   localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CW = $clog2(MAX_PAIRS + 1);

   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     j_ff, j_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [PAIR_W-1:0] item_ff, item_in;
   logic              last_ff, last_in;
   logic [KEY_W-1:0]  first_ff, first_in;
   logic [KEY_W-1:0]  second_ff, second_in;
   logic              run_last_ff, run_last_in;

   logic [CW-1:0]     j_prev;
   logic [AW-1:0]     rd_addr;
   logic [PAIR_W-1:0] wr_data;
   logic [PAIR_W-1:0] rd_data;

   assign j_prev  = j_ff - CW'(1);
   assign rd_addr = cmd.rd_emit ? k_ff[AW-1:0] : j_prev[AW-1:0];
   assign wr_data = cmd.wr_shift ? rd_data : item_ff;

   plsort_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (MAX_PAIRS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (j_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in    = count_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      item_in     = item_ff;
      last_in     = last_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      run_last_in = run_last_ff;
      if (cmd.load_item) begin
         item_in = pack_pair(req_key_first, req_key_second);
         last_in = req_batch_last;
         j_in    = count_ff;
         k_in    = '0;
      end
      if (cmd.j_dec) begin
         j_in = j_prev;
      end
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.count_clear) begin
         count_in = '0;
      end
      if (cmd.k_inc) begin
         k_in = k_ff + CW'(1);
      end
      if (cmd.out_load) begin
         first_in    = rd_data[PAIR_W-1:KEY_W] ^ SIGN_FLIP;
         second_in   = rd_data[KEY_W-1:0] ^ SIGN_FLIP;
         run_last_in = status.k_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      j_ff        <= j_in;
      k_ff        <= k_in;
      item_ff     <= item_in;
      last_ff     <= last_in;
      first_ff    <= first_in;
      second_ff   <= second_in;
      run_last_ff <= run_last_in;
   end

   assign status.full    = (count_ff == CW'(MAX_PAIRS));
   assign status.j_zero  = (j_ff == '0);
   assign status.greater = (rd_data > item_ff);
   assign status.last    = last_ff;
   assign status.k_last  = ((k_ff + CW'(1)) == count_ff);

   assign rsp_sorted_first  = signed'(first_ff);
   assign rsp_sorted_second = signed'(second_ff);
   assign rsp_run_last      = run_last_ff;

endmodule
`default_nettype wire

### src/plsort_ctrl.sv
// controller: sequences insertion into the store and emission of the run
`default_nettype none
module plsort_ctrl
   import plsort_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_batch_last,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      IDLE,
      INS_READ,
      INS_CMP,
      EMIT_READ,
      EMIT_WAIT,
      EMIT_HOLD
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (!status.full) begin
                  state_in = INS_READ;
               end else if (req_batch_last) begin
                  // store full: pair dropped, flag still closes the batch
                  state_in = EMIT_READ;
               end
            end
         end
         INS_READ: begin
            if (status.j_zero) begin
               cmd.wr_en     = 1'b1;
               cmd.count_inc = 1'b1;
               state_in      = status.last ? EMIT_READ : IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = INS_CMP;
            end
         end
         INS_CMP: begin
            cmd.wr_en = 1'b1;
            if (status.greater) begin
               // move the larger entry up one place and keep looking down
               cmd.wr_shift = 1'b1;
               cmd.j_dec    = 1'b1;
               state_in     = INS_READ;
            end else begin
               cmd.count_inc = 1'b1;
               state_in      = status.last ? EMIT_READ : IDLE;
            end
         end
         EMIT_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_emit = 1'b1;
            state_in    = EMIT_WAIT;
         end
         EMIT_WAIT: begin
            cmd.out_load = 1'b1;
            state_in     = EMIT_HOLD;
         end
         EMIT_HOLD: begin
            if (!rsp_stall) begin
               if (status.k_last) begin
                  cmd.count_clear = 1'b1;
                  state_in        = IDLE;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in  = EMIT_READ;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = (state_ff == EMIT_HOLD);

   a_no_accept_while_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a sorted pair is presented");

   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == INS_CMP) |-> ($past(state_ff) == INS_READ))
      else $error("compare without a preceding store read");

   a_wait_then_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT_WAIT) |=> (state_ff == EMIT_HOLD))
      else $error("read data not loaded into the output register");

   a_shift_not_at_bottom: assert property (@(posedge clock) disable iff (reset)
      cmd.j_dec |-> !status.j_zero)
      else $error("insertion pointer moved below the first entry");

endmodule
`default_nettype wire

### dv/plsort_checker.sv
// checker of the pair sorter: mirrors the batch store, predicts the sorted run, compares results
`timescale 1ns / 100ps
module plsort_checker
   import plsort_pkg::*;
#(
   parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_stall,
   input  wire logic signed [KEY_W-1:0] req_key_first,
   input  wire logic signed [KEY_W-1:0] req_key_second,
   input  wire logic                    req_batch_last,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire logic signed [KEY_W-1:0] rsp_sorted_first,
   input  wire logic signed [KEY_W-1:0] rsp_sorted_second,
   input  wire logic                    rsp_run_last,
   output int                           fail_count,
   output int                           pending_results
);

   typedef struct {
      logic signed [KEY_W-1:0] first;
      logic signed [KEY_W-1:0] second;
      logic                    run_last;
   } sorted_pair_type;

   logic signed [KEY_W-1:0] batch_first  [MAX_PAIRS];
   logic signed [KEY_W-1:0] batch_second [MAX_PAIRS];
   int                      batch_count;
   sorted_pair_type         sorted_q [$];

   // lexicographic order on signed keys, first key dominant
   function automatic bit pair_above(input logic signed [KEY_W-1:0] a_first,
                                     input logic signed [KEY_W-1:0] a_second,
                                     input logic signed [KEY_W-1:0] b_first,
                                     input logic signed [KEY_W-1:0] b_second);
      return (a_first > b_first) || (a_first == b_first && a_second > b_second);
   endfunction

   always @(posedge clock) begin : watch
      int i;
      int j;
      logic signed [KEY_W-1:0] hold_first;
      logic signed [KEY_W-1:0] hold_second;
      sorted_pair_type want;
      if (reset) begin
         batch_count = 0;
         sorted_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sorted_q.size() == 0) begin
               $error("unexpected result: first %0d, second %0d, run_last %0b",
                      rsp_sorted_first, rsp_sorted_second, rsp_run_last);
               fail_count++;
            end else begin
               want = sorted_q.pop_front();
               if (rsp_sorted_first !== want.first) begin
                  $error("sorted_first mismatch: expected %0d, got %0d",
                         want.first, rsp_sorted_first);
                  fail_count++;
               end
               if (rsp_sorted_second !== want.second) begin
                  $error("sorted_second mismatch: expected %0d, got %0d",
                         want.second, rsp_sorted_second);
                  fail_count++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $error("run_last mismatch: expected %0b, got %0b",
                         want.run_last, rsp_run_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            // pairs beyond capacity are dropped, but their last flag still counts
            if (batch_count < MAX_PAIRS) begin
               batch_first[batch_count]  = req_key_first;
               batch_second[batch_count] = req_key_second;
               batch_count++;
            end
            if (req_batch_last) begin
               for (i = 1; i < batch_count; i++) begin
                  hold_first  = batch_first[i];
                  hold_second = batch_second[i];
                  j = i;
                  while (j > 0 && pair_above(batch_first[j-1], batch_second[j-1],
                                             hold_first, hold_second)) begin
                     batch_first[j]  = batch_first[j-1];
                     batch_second[j] = batch_second[j-1];
                     j--;
                  end
                  batch_first[j]  = hold_first;
                  batch_second[j] = hold_second;
               end
               for (i = 0; i < batch_count; i++) begin
                  want.first    = batch_first[i];
                  want.second   = batch_second[i];
                  want.run_last = (i == batch_count - 1);
                  sorted_q.push_back(want);
               end
               batch_count = 0;
            end
         end
      end
      pending_results = sorted_q.size();
   end

endmodule

### dv/tb.sv
// top of the pair sorter testbench: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 100ps
module tb;
   import plsort_pkg::*;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = ~KEY_MIN;
   localparam int RANDOM_ITEMS = 300;
   localparam int LONG_HOLD    = 400;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic signed [KEY_W-1:0] req_key_first  = '0;
   logic signed [KEY_W-1:0] req_key_second = '0;
   logic                    req_batch_last = 1'b0;
   logic                    rsp_stall      = 1'b0;
   bit                      hold_request   = 1'b0;

   wire logic                    req_stall;
   wire logic                    rsp_valid;
   wire logic signed [KEY_W-1:0] rsp_sorted_first;
   wire logic signed [KEY_W-1:0] rsp_sorted_second;
   wire logic                    rsp_run_last;
   int                           fail_count;
   int                           pending_results;

   pair_lexicographic_sorter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_key_first     (req_key_first),
      .req_key_second    (req_key_second),
      .req_batch_last    (req_batch_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sorted_first  (rsp_sorted_first),
      .rsp_sorted_second (rsp_sorted_second),
      .rsp_run_last      (rsp_run_last)
   );

   plsort_checker chk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_key_first     (req_key_first),
      .req_key_second    (req_key_second),
      .req_batch_last    (req_batch_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sorted_first  (rsp_sorted_first),
      .rsp_sorted_second (rsp_sorted_second),
      .rsp_run_last      (rsp_run_last),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   always #1 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10)
         return 0;
      else if (r < 17)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // biased towards extremes and a narrow band so that ties are common
   function automatic logic signed [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return KEY_MIN;
      else if (r == 1)
         return KEY_MAX;
      else if (r < 5)
         return $signed(KEY_W'($urandom_range(0, 4))) - 2;
      return $signed(KEY_W'($urandom));
   endfunction

   task automatic send_pair(input logic signed [KEY_W-1:0] first,
                            input logic signed [KEY_W-1:0] second,
                            input bit last, input bit calm);
      int gap;
      gap = calm ? 0 : idle_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_key_first  <= first;
      req_key_second <= second;
      req_batch_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int sent;
      int batch_no;
      int size;
      bit calm;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // single pair batch
      send_pair(KEY_MAX, KEY_MIN, 1'b1, 1'b0);
      // extremes in both keys
      send_pair(KEY_MAX, KEY_MAX, 1'b0, 1'b0);
      send_pair(KEY_MIN, KEY_MIN, 1'b0, 1'b1);
      send_pair(KEY_MIN, KEY_MAX, 1'b0, 1'b1);
      send_pair(KEY_MAX, KEY_MIN, 1'b0, 1'b0);
      send_pair(0, -1, 1'b0, 1'b0);
      send_pair(-1, 0, 1'b0, 1'b1);
      send_pair(-1, -1, 1'b1, 1'b0);
      // equal pairs and ties on the first key
      send_pair(5, 5, 1'b0, 1'b1);
      send_pair(5, 5, 1'b0, 1'b1);
      send_pair(5, -5, 1'b0, 1'b1);
      send_pair(5, 5, 1'b1, 1'b1);
      // already ascending, then descending
      send_pair(1, 0, 1'b0, 1'b0);
      send_pair(2, 0, 1'b0, 1'b0);
      send_pair(3, 0, 1'b1, 1'b0);
      send_pair(3, 7, 1'b0, 1'b1);
      send_pair(-2, 7, 1'b0, 1'b1);
      send_pair(-3, 7, 1'b1, 1'b1);
      drain_results();

      sent     = 0;
      batch_no = 0;
      while (sent < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         // one batch drops its flagged last pair; another fills or overflows the store
         if (batch_no == 4)
            size = MAX_PAIRS_DEF + 1;
         else if (batch_no == 12)
            size = $urandom_range(MAX_PAIRS_DEF, MAX_PAIRS_DEF + 6);
         else if ($urandom_range(0, 7) == 0)
            size = $urandom_range(9, 20);
         else
            size = $urandom_range(1, 8);
         for (int i = 0; i < size; i++)
            send_pair(pick_key(), pick_key(), i == size - 1, calm);
         sent += size;
         // receiver stalls for the LONG_HOLD stretch while the next batch waits on req_stall
         if (batch_no == 2)
            hold_request = 1'b1;
         if ($urandom_range(0, 5) == 0)
            drain_results();
         batch_no++;
      end

      drain_results();
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin : rsp_side
      int stall_left;
      int run_left;
      bit hold_taken;
      stall_left = 0;
      run_left   = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = LONG_HOLD;
            run_left   = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_stall <= 1'b0;
            run_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_gap();
            run_left   = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(0, 16);
         end
      end
   end

   initial begin : watchdog
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
